// ----- sv/wspc_pkg.sv -----
// Shared types and constants for the wheel speed PID controller.
// No dependencies; every other file in sv/ uses this package.
package wspc_pkg;

    // Field and datapath widths fixed by the fixed-point formats.
    localparam int GAIN_W   = 16;   // gains, scale and setpoint registers
    localparam int SPEED_W  = 18;   // Q10.8 speed and error
    localparam int DELTA_W  = 19;   // error difference
    localparam int INT_W    = 32;   // integral accumulator
    localparam int DUTY_W   = 7;
    localparam int ACC_W    = 50;   // product accumulator, holds the full PID sum
    localparam int CNT_W    = $clog2(GAIN_W + 1);
    localparam int CFG_IDX_W = 3;

    localparam logic [DUTY_W-1:0] DUTY_MAX = 7'd100;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SETPOINT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KP       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KI       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KD       = 3'd4;

    // Reset values: scale is 50 / (14 * 35) in Q0.16, gains 50, 15 and 30 in Q8.8.
    localparam logic [GAIN_W-1:0] SCALE_RST = 16'd6687;
    localparam logic [GAIN_W-1:0] KP_RST    = 16'd12800;
    localparam logic [GAIN_W-1:0] KI_RST    = 16'd3840;
    localparam logic [GAIN_W-1:0] KD_RST    = 16'd7680;

    typedef struct packed {
        logic signed [GAIN_W-1:0] setpoint;
        logic [GAIN_W-1:0]        scale;
        logic [GAIN_W-1:0]        kp;
        logic [GAIN_W-1:0]        ki;
        logic [GAIN_W-1:0]        kd;
    } t_cfg;

    // Command from the sequencer to the serial multiply-accumulate unit.
    typedef struct packed {
        logic load;     // start a new product
        logic clr_acc;  // clear the accumulator before the product is added
    } t_mac_cmd;

endpackage

// ----- sv/wheel_speed_pid_controller.sv -----
// Top level of the wheel speed PID controller: sequencer, error and integral
// update, duty clamp and output register. Uses wspc_pkg, wspc_cfg_regs, wspc_serial_mac.
//
//   Channel   Direction  Handshake            Payload
//   input     in         i_valid / o_ready    i_tick_count
//   result    out        o_valid / i_ready    o_duty_percent, o_measured_speed
//   config    in         i_cfg_we             i_cfg_idx, i_cfg_data
//
// A new request is taken only after the last result is written to the output
// register. Four 16-bit products run one multiplier bit per cycle through the
// shared serial multiply-accumulate unit, besides the speed, error and integral
// update steps, the duty clamp and the return to idle.
// Reset is synchronous and active low; it restores the register defaults and
// clears the integral and the previous error. A stalled result waits in the
// output register while the next request is taken; the sequencer holds before
// writing a new result until the old one is taken.
module wheel_speed_pid_controller #(
    parameter int TICK_WIDTH = 12
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic signed [TICK_WIDTH-1:0]         i_tick_count,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [wspc_pkg::DUTY_W-1:0]          o_duty_percent,
    output logic signed [wspc_pkg::SPEED_W-1:0]  o_measured_speed,
    input  logic                                 i_cfg_we,
    input  logic [wspc_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [wspc_pkg::GAIN_W-1:0]          i_cfg_data
);

    localparam int ACC_W   = wspc_pkg::ACC_W;
    localparam int SPEED_W = wspc_pkg::SPEED_W;
    localparam int DELTA_W = wspc_pkg::DELTA_W;
    localparam int INT_W   = wspc_pkg::INT_W;
    localparam int GAIN_W  = wspc_pkg::GAIN_W;
    localparam int SHIFT_W = ACC_W - 8;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MSPD = 4'd1;
    localparam logic [3:0] S_SPD  = 4'd2;
    localparam logic [3:0] S_ERR  = 4'd3;
    localparam logic [3:0] S_INT  = 4'd4;
    localparam logic [3:0] S_MKP  = 4'd5;
    localparam logic [3:0] S_MKI  = 4'd6;
    localparam logic [3:0] S_MKD  = 4'd7;
    localparam logic [3:0] S_FIN  = 4'd8;

    wspc_pkg::t_cfg     w_cfg;
    wspc_pkg::t_mac_cmd w_mac_cmd;
    logic [ACC_W-1:0]   w_mcand;
    logic [GAIN_W-1:0]  w_mplier;
    logic [ACC_W-1:0]   w_acc;
    logic               w_mac_busy;

    logic [3:0]                 r_state, n_state;
    logic signed [SPEED_W-1:0]  r_speed;
    logic signed [SPEED_W-1:0]  r_err;
    logic signed [SPEED_W-1:0]  r_last_err;
    logic signed [DELTA_W-1:0]  r_delta;
    logic signed [INT_W-1:0]    r_integral;
    logic                       r_out_valid;
    logic [wspc_pkg::DUTY_W-1:0] r_duty;
    logic signed [SPEED_W-1:0]  r_out_speed;

    logic [SHIFT_W-1:0]         w_shift;
    logic signed [SPEED_W-1:0]  w_speed_sat;
    logic signed [SPEED_W:0]    w_err_full;
    logic signed [SPEED_W-1:0]  w_err_sat;
    logic signed [INT_W:0]      w_int_full;
    logic signed [INT_W-1:0]    w_int_sat;
    logic signed [DELTA_W-1:0]  w_delta;
    logic [wspc_pkg::DUTY_W-1:0] w_duty;
    logic                       w_out_free;

    wspc_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    wspc_serial_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_mac_cmd),
        .i_mcand  (w_mcand),
        .i_mplier (w_mplier),
        .o_acc    (w_acc),
        .o_busy   (w_mac_busy)
    );

    // Speed is the product floored by 256, saturated to 18 bits.
    assign w_shift = w_acc[ACC_W-1:8];
    always_comb begin
        if (&w_shift[SHIFT_W-1:SPEED_W-1] || ~|w_shift[SHIFT_W-1:SPEED_W-1]) begin
            w_speed_sat = w_shift[SPEED_W-1:0];
        end else begin
            w_speed_sat = {w_shift[SHIFT_W-1], {(SPEED_W-1){~w_shift[SHIFT_W-1]}}};
        end
    end

    assign w_err_full = {{(SPEED_W+1-GAIN_W){w_cfg.setpoint[GAIN_W-1]}}, w_cfg.setpoint}
                      - {r_speed[SPEED_W-1], r_speed};
    always_comb begin
        if (w_err_full[SPEED_W] == w_err_full[SPEED_W-1]) begin
            w_err_sat = w_err_full[SPEED_W-1:0];
        end else begin
            w_err_sat = {w_err_full[SPEED_W], {(SPEED_W-1){~w_err_full[SPEED_W]}}};
        end
    end

    assign w_int_full = {r_integral[INT_W-1], r_integral}
                      + {{(INT_W+1-SPEED_W){r_err[SPEED_W-1]}}, r_err};
    always_comb begin
        if (w_int_full[INT_W] == w_int_full[INT_W-1]) begin
            w_int_sat = w_int_full[INT_W-1:0];
        end else begin
            w_int_sat = {w_int_full[INT_W], {(INT_W-1){~w_int_full[INT_W]}}};
        end
    end

    assign w_delta = {r_err[SPEED_W-1], r_err} - {r_last_err[SPEED_W-1], r_last_err};

    // Truncation toward zero only matters for negative sums, which give zero duty.
    always_comb begin
        if (w_acc[ACC_W-1]) begin
            w_duty = '0;
        end else if (w_acc[ACC_W-2:16] > (ACC_W-17)'(wspc_pkg::DUTY_MAX)) begin
            w_duty = wspc_pkg::DUTY_MAX;
        end else begin
            w_duty = w_acc[16 +: wspc_pkg::DUTY_W];
        end
    end

    assign w_out_free = !r_out_valid || i_ready;

    // Operand selection and sequencing.
    always_comb begin
        n_state           = r_state;
        w_mac_cmd.load    = 1'b0;
        w_mac_cmd.clr_acc = 1'b0;
        w_mcand           = '0;
        w_mplier          = '0;
        case (r_state)
            S_IDLE: begin
                w_mcand  = {{(ACC_W-TICK_WIDTH){i_tick_count[TICK_WIDTH-1]}}, i_tick_count};
                w_mplier = w_cfg.scale;
                if (i_valid) begin
                    w_mac_cmd.load    = 1'b1;
                    w_mac_cmd.clr_acc = 1'b1;
                    n_state           = S_MSPD;
                end
            end
            S_MSPD: begin
                if (!w_mac_busy) begin
                    n_state = S_SPD;
                end
            end
            S_SPD: n_state = S_ERR;
            S_ERR: n_state = S_INT;
            S_INT: begin
                w_mcand           = {{(ACC_W-SPEED_W){r_err[SPEED_W-1]}}, r_err};
                w_mplier          = w_cfg.kp;
                w_mac_cmd.load    = 1'b1;
                w_mac_cmd.clr_acc = 1'b1;
                n_state           = S_MKP;
            end
            S_MKP: begin
                w_mcand  = {{(ACC_W-INT_W){r_integral[INT_W-1]}}, r_integral};
                w_mplier = w_cfg.ki;
                if (!w_mac_busy) begin
                    w_mac_cmd.load = 1'b1;
                    n_state        = S_MKI;
                end
            end
            S_MKI: begin
                w_mcand  = {{(ACC_W-DELTA_W){r_delta[DELTA_W-1]}}, r_delta};
                w_mplier = w_cfg.kd;
                if (!w_mac_busy) begin
                    w_mac_cmd.load = 1'b1;
                    n_state        = S_MKD;
                end
            end
            S_MKD: begin
                if (!w_mac_busy) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_integral  <= '0;
            r_last_err  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_INT) begin
                r_integral <= w_int_sat;
                r_last_err <= r_err;
            end
            if (r_state == S_FIN && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_SPD) begin
            r_speed <= w_speed_sat;
        end
        if (r_state == S_ERR) begin
            r_err <= w_err_sat;
        end
        if (r_state == S_INT) begin
            r_delta <= w_delta;
        end
        if (r_state == S_FIN && w_out_free) begin
            r_duty      <= w_duty;
            r_out_speed <= r_speed;
        end
    end

    assign o_ready          = (r_state == S_IDLE);
    assign o_valid          = r_out_valid;
    assign o_duty_percent   = r_duty;
    assign o_measured_speed = r_out_speed;

    a_duty_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_duty <= wspc_pkg::DUTY_MAX))
        else $error("duty above the clamp limit");

    a_fin_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && w_out_free) |=> r_out_valid)
        else $error("finished request did not reach the output register");

    a_mac_done_before_speed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SPD || r_state == S_FIN) |-> !w_mac_busy)
        else $error("product used before the multiply finished");

endmodule

// ----- sv/wspc_cfg_regs.sv -----
// Configuration register file of the wheel speed PID controller.
// Depends on wspc_pkg for the register indexes, reset values and t_cfg.
module wspc_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [wspc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [wspc_pkg::GAIN_W-1:0]      i_cfg_data,
    output wspc_pkg::t_cfg                   o_cfg
);

    wspc_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.setpoint <= '0;
            r_cfg.scale    <= wspc_pkg::SCALE_RST;
            r_cfg.kp       <= wspc_pkg::KP_RST;
            r_cfg.ki       <= wspc_pkg::KI_RST;
            r_cfg.kd       <= wspc_pkg::KD_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                wspc_pkg::REG_SETPOINT: r_cfg.setpoint <= i_cfg_data;
                wspc_pkg::REG_SCALE:    r_cfg.scale    <= i_cfg_data;
                wspc_pkg::REG_KP:       r_cfg.kp       <= i_cfg_data;
                wspc_pkg::REG_KI:       r_cfg.ki       <= i_cfg_data;
                wspc_pkg::REG_KD:       r_cfg.kd       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- sv/wspc_serial_mac.sv -----
// Bit-serial multiply-accumulate unit: one multiplier bit per cycle.
// Depends on wspc_pkg for widths and the t_mac_cmd command struct.
module wspc_serial_mac (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  wspc_pkg::t_mac_cmd                i_cmd,
    input  logic [wspc_pkg::ACC_W-1:0]        i_mcand,
    input  logic [wspc_pkg::GAIN_W-1:0]       i_mplier,
    output logic [wspc_pkg::ACC_W-1:0]        o_acc,
    output logic                              o_busy
);

    logic [wspc_pkg::CNT_W-1:0]  r_cnt;
    logic [wspc_pkg::ACC_W-1:0]  r_mcand;
    logic [wspc_pkg::GAIN_W-1:0] r_mplier;
    logic [wspc_pkg::ACC_W-1:0]  r_acc;
    logic                        w_busy;

    assign w_busy = (r_cnt != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.load) begin
            r_cnt <= wspc_pkg::CNT_W'(wspc_pkg::GAIN_W);
        end else if (w_busy) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // The multiplicand shifts left while the multiplier shifts right, so the
    // low multiplier bit always selects whether the shifted multiplicand is added.
    // Two's complement wraps correctly because the full sum fits the accumulator.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mcand  <= i_mcand;
            r_mplier <= i_mplier;
            if (i_cmd.clr_acc) begin
                r_acc <= '0;
            end
        end else if (w_busy) begin
            if (r_mplier[0]) begin
                r_acc <= r_acc + r_mcand;
            end
            r_mcand  <= {r_mcand[wspc_pkg::ACC_W-2:0], 1'b0};
            r_mplier <= {1'b0, r_mplier[wspc_pkg::GAIN_W-1:1]};
        end
    end

    assign o_acc  = r_acc;
    assign o_busy = w_busy;

    a_no_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |-> !w_busy)
        else $error("multiply started while a product is in progress");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= wspc_pkg::CNT_W'(wspc_pkg::GAIN_W))
        else $error("bit counter out of range");

    a_acc_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_busy && !i_cmd.load) |=> $stable(r_acc))
        else $error("accumulator changed while the unit is idle");

endmodule

// ----- tb/sv/wspc_pid_checker.sv -----
`timescale 1ns / 100ps
// Checker for the wheel speed PID controller: it watches the request, result and
// register write ports, predicts duty and speed per request and compares. Uses wspc_pkg.
module wspc_pid_checker #(
    parameter int TICK_WIDTH = 12
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_req_valid,
    input  logic                                i_req_ready,
    input  logic signed [TICK_WIDTH-1:0]        i_tick_count,
    input  logic                                i_res_valid,
    input  logic                                i_res_ready,
    input  logic [wspc_pkg::DUTY_W-1:0]         i_duty_percent,
    input  logic signed [wspc_pkg::SPEED_W-1:0] i_measured_speed,
    input  logic                                i_cfg_we,
    input  logic [wspc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [wspc_pkg::GAIN_W-1:0]         i_cfg_data,
    output int                                  o_errors,
    output int                                  o_pending
);

    localparam longint SPEED_HI = (longint'(1) <<< (wspc_pkg::SPEED_W - 1)) - 1;
    localparam longint SPEED_LO = -(longint'(1) <<< (wspc_pkg::SPEED_W - 1));
    localparam longint INTEG_HI = (longint'(1) <<< (wspc_pkg::INT_W - 1)) - 1;
    localparam longint INTEG_LO = -(longint'(1) <<< (wspc_pkg::INT_W - 1));
    // Ticks times a Q0.16 scale leaves 16 fraction bits; Q10.8 keeps eight of them.
    localparam int     SCALE_SHIFT = 8;
    // Q8.8 gains times Q10.8 errors carry sixteen fraction bits.
    localparam longint CMD_DIV = longint'(1) <<< 16;

    typedef struct {
        logic [wspc_pkg::DUTY_W-1:0]         duty;
        logic signed [wspc_pkg::SPEED_W-1:0] speed;
    } t_motor_cmd;

    wspc_pkg::t_cfg                      cfg;
    logic signed [wspc_pkg::INT_W-1:0]   err_integral;
    logic signed [wspc_pkg::SPEED_W-1:0] prev_err;
    t_motor_cmd                          motor_cmd_q[$];

    function automatic longint clamp_to(input longint v, input longint lo, input longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // Advances the controller state by one sample and returns the motor command.
    function automatic t_motor_cmd next_motor_cmd(input logic signed [TICK_WIDTH-1:0] tick);
        longint     speed;
        longint     err;
        longint     delta;
        longint     cmd;
        t_motor_cmd res;
        // The arithmetic shift floors negative speeds toward minus infinity.
        speed = clamp_to((longint'(tick) * longint'(cfg.scale)) >>> SCALE_SHIFT,
                         SPEED_LO, SPEED_HI);
        err = clamp_to(longint'($signed(cfg.setpoint)) - speed, SPEED_LO, SPEED_HI);
        err_integral = wspc_pkg::INT_W'(clamp_to(longint'(err_integral) + err,
                                                 INTEG_LO, INTEG_HI));
        delta = err - longint'(prev_err);
        prev_err = wspc_pkg::SPEED_W'(err);
        // Division of a signed longint truncates toward zero.
        cmd = (longint'(cfg.kp) * err + longint'(cfg.ki) * longint'(err_integral)
               + longint'(cfg.kd) * delta) / CMD_DIV;
        if (cmd < 0)
            res.duty = '0;
        else if (cmd > longint'(wspc_pkg::DUTY_MAX))
            res.duty = wspc_pkg::DUTY_MAX;
        else
            res.duty = wspc_pkg::DUTY_W'(cmd);
        res.speed = wspc_pkg::SPEED_W'(speed);
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_motor_cmd want;
        if (!i_rst_n) begin
            cfg.setpoint = '0;
            cfg.scale    = wspc_pkg::SCALE_RST;
            cfg.kp       = wspc_pkg::KP_RST;
            cfg.ki       = wspc_pkg::KI_RST;
            cfg.kd       = wspc_pkg::KD_RST;
            err_integral = '0;
            prev_err     = '0;
            motor_cmd_q.delete();
        end else begin
            if (i_res_valid && i_res_ready) begin
                if (motor_cmd_q.size() == 0) begin
                    o_errors++;
                    $error("result with no request outstanding: duty %0d, speed %0d",
                           i_duty_percent, i_measured_speed);
                end else begin
                    want = motor_cmd_q.pop_front();
                    if (want.duty !== i_duty_percent) begin
                        o_errors++;
                        $error("duty_percent: expected %0d, got %0d",
                               want.duty, i_duty_percent);
                    end
                    if (want.speed !== i_measured_speed) begin
                        o_errors++;
                        $error("measured_speed: expected %0d, got %0d",
                               want.speed, i_measured_speed);
                    end
                end
            end
            if (i_req_valid && i_req_ready)
                motor_cmd_q.push_back(next_motor_cmd(i_tick_count));
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    wspc_pkg::REG_SETPOINT: cfg.setpoint = i_cfg_data;
                    wspc_pkg::REG_SCALE:    cfg.scale    = i_cfg_data;
                    wspc_pkg::REG_KP:       cfg.kp       = i_cfg_data;
                    wspc_pkg::REG_KI:       cfg.ki       = i_cfg_data;
                    wspc_pkg::REG_KD:       cfg.kd       = i_cfg_data;
                    default: ;
                endcase
            end
        end
        o_pending = motor_cmd_q.size();
    end

endmodule

// ----- tb/sv/tb_wheel_speed_pid_controller.sv -----
`timescale 1ns / 100ps
// Top of the wheel speed PID controller testbench: clock, reset, stimulus and verdict.
// Depends on wspc_pkg, wheel_speed_pid_controller and wspc_pid_checker.
module tb_wheel_speed_pid_controller;

    localparam int TICK_W          = 12;
    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int SETTLE_CYCLES   = 8;
    localparam int DRAIN_CYCLES    = 80;    // one full request through the block
    localparam int RANDOM_PHASES   = 12;
    localparam int ITEMS_PER_PHASE = 70;
    // A stretch of saturated errors that drives the integral far from zero.
    localparam int WINDUP_ITEMS    = 30;
    localparam int UNWIND_ITEMS    = 30;

    typedef enum int {CFG_TYPICAL, CFG_ANY, CFG_EXTREME} t_cfg_kind;

    // Idle modes: none, sender idle, receiver stalling, both lightly.
    int send_idle_tab[4] = '{0, 87, 0, 8};
    int stall_tab[4]     = '{0, 0, 87, 8};

    logic                                i_clk;
    logic                                i_rst_n;
    logic                                i_valid;
    logic                                o_ready;
    logic signed [TICK_W-1:0]            i_tick_count;
    logic                                o_valid;
    logic                                i_ready = 1'b0;
    logic [wspc_pkg::DUTY_W-1:0]         o_duty_percent;
    logic signed [wspc_pkg::SPEED_W-1:0] o_measured_speed;
    logic                                i_cfg_we;
    logic [wspc_pkg::CFG_IDX_W-1:0]      i_cfg_idx;
    logic [wspc_pkg::GAIN_W-1:0]         i_cfg_data;

    int check_errors;
    int cmds_pending;
    int cycle_count   = 0;
    int send_idle_pct = 0;
    int stall_pct     = 0;

    wheel_speed_pid_controller #(
        .TICK_WIDTH(TICK_W)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_tick_count    (i_tick_count),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_duty_percent  (o_duty_percent),
        .o_measured_speed(o_measured_speed),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data)
    );

    wspc_pid_checker #(
        .TICK_WIDTH(TICK_W)
    ) u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req_valid     (i_valid),
        .i_req_ready     (o_ready),
        .i_tick_count    (i_tick_count),
        .i_res_valid     (o_valid),
        .i_res_ready     (i_ready),
        .i_duty_percent  (o_duty_percent),
        .i_measured_speed(o_measured_speed),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .o_errors        (check_errors),
        .o_pending       (cmds_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_wheel_speed_pid_controller: errors");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Presents one request and returns at the falling edge after it is taken,
    // with valid still high so that a following request can go out back to back.
    task automatic send_tick(input logic signed [TICK_W-1:0] tick);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_tick_count <= tick;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [wspc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [wspc_pkg::GAIN_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
    endtask

    // Writes all registers, then one index that decodes to nothing.
    task automatic load_settings(input wspc_pkg::t_cfg c);
        write_reg(wspc_pkg::REG_SETPOINT, c.setpoint);
        write_reg(wspc_pkg::REG_SCALE, c.scale);
        write_reg(wspc_pkg::REG_KP, c.kp);
        write_reg(wspc_pkg::REG_KI, c.ki);
        write_reg(wspc_pkg::REG_KD, c.kd);
        write_reg(wspc_pkg::CFG_IDX_W'($urandom_range(int'(wspc_pkg::REG_KD) + 1,
                                                      (1 << wspc_pkg::CFG_IDX_W) - 1)),
                  wspc_pkg::GAIN_W'($urandom));
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (cmds_pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    function automatic wspc_pkg::t_cfg pick_cfg(input t_cfg_kind k);
        wspc_pkg::t_cfg c;
        case (k)
            CFG_TYPICAL: begin
                // A few rev/s either way, near-nominal scale and modest gains.
                c.setpoint = wspc_pkg::GAIN_W'(int'($urandom_range(2048)) - 1024);
                c.scale    = wspc_pkg::GAIN_W'($urandom_range(3000, 10000));
                c.kp       = wspc_pkg::GAIN_W'($urandom_range(12800));
                c.ki       = wspc_pkg::GAIN_W'($urandom_range(256));
                c.kd       = wspc_pkg::GAIN_W'($urandom_range(7680));
            end
            CFG_ANY: begin
                c.setpoint = wspc_pkg::GAIN_W'($urandom);
                c.scale    = wspc_pkg::GAIN_W'($urandom);
                c.kp       = wspc_pkg::GAIN_W'($urandom);
                c.ki       = wspc_pkg::GAIN_W'($urandom);
                c.kd       = wspc_pkg::GAIN_W'($urandom);
            end
            default: begin
                case ($urandom_range(2))
                    0:       c.setpoint = 16'h8000;
                    1:       c.setpoint = 16'h7FFF;
                    default: c.setpoint = '0;
                endcase
                c.scale = $urandom_range(1) ? '1 : '0;
                c.kp    = $urandom_range(1) ? '1 : '0;
                c.ki    = $urandom_range(1) ? '1 : '0;
                c.kd    = $urandom_range(1) ? '1 : '0;
            end
        endcase
        return c;
    endfunction

    function automatic logic signed [TICK_W-1:0] pick_tick();
        int sel;
        sel = $urandom_range(9);
        if (sel == 0)
            return $urandom_range(1) ? {1'b0, {(TICK_W-1){1'b1}}} : {1'b1, {(TICK_W-1){1'b0}}};
        if (sel < 5)
            return TICK_W'($urandom);
        return TICK_W'(int'($urandom_range(64)) - 32);
    endfunction

    initial begin
        int ph;
        i_rst_n      <= 1'b0;
        i_valid      <= 1'b0;
        i_tick_count <= '0;
        i_cfg_we     <= 1'b0;
        i_cfg_idx    <= '0;
        i_cfg_data   <= '0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Register defaults straight out of reset.
        send_tick(12'sd0);
        send_tick(12'sd2047);
        send_tick(-12'sd2048);
        send_tick(12'sd1);
        send_tick(-12'sd1);
        send_tick(12'sd100);

        // Speed saturating both ways, error saturating high, command far above full duty.
        wait_idle();
        load_settings('{16'h7FFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF});
        send_tick(-12'sd2048);
        send_tick(12'sd2047);
        send_tick(-12'sd2048);
        send_tick(12'sd0);

        // Error saturating low, so the command goes negative.
        wait_idle();
        load_settings('{16'h8000, 16'hFFFF, 16'h0100, 16'hFFFF, 16'h0000});
        send_tick(12'sd2047);
        send_tick(12'sd2047);
        send_tick(12'sd0);

        // Zero scale and zero gains.
        wait_idle();
        load_settings('{16'h0100, 16'h0000, 16'h0000, 16'h0000, 16'h0000});
        send_tick(12'sd2047);
        send_tick(-12'sd2048);

        // Default scale and Kp, small setpoint and Ki, no Kd, so the duty lands in range.
        wait_idle();
        load_settings('{16'h0100, wspc_pkg::SCALE_RST, wspc_pkg::KP_RST, 16'h0010, 16'h0000});
        send_tick(12'sd0);
        send_tick(12'sd5);
        send_tick(12'sd10);
        send_tick(-12'sd3);

        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            wait_idle();
            load_settings(pick_cfg(t_cfg_kind'(ph / 4)));
            send_idle_pct = send_idle_tab[ph % 4];
            stall_pct     = stall_tab[ph % 4];
            repeat (ITEMS_PER_PHASE) send_tick(pick_tick());
        end

        // Hold the error at its positive limit for a stretch, then pull it back
        // the other way.
        wait_idle();
        send_idle_pct = 0;
        stall_pct     = 0;
        load_settings('{16'h7FFF, 16'hFFFF, wspc_pkg::GAIN_W'($urandom),
                        wspc_pkg::GAIN_W'($urandom), wspc_pkg::GAIN_W'($urandom)});
        repeat (WINDUP_ITEMS) send_tick(TICK_W'(-int'($urandom_range(400, 2048))));
        wait_idle();
        load_settings('{16'h8000, 16'hFFFF, wspc_pkg::GAIN_W'($urandom),
                        wspc_pkg::GAIN_W'($urandom), wspc_pkg::GAIN_W'($urandom)});
        repeat (UNWIND_ITEMS) send_tick(TICK_W'($urandom_range(400, 2047)));

        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (check_errors == 0)
            $display("tb_wheel_speed_pid_controller: clean");
        else
            $display("tb_wheel_speed_pid_controller: errors");
        $finish;
    end

endmodule
